/* rtl/ppe_pkg.sv */
// Shared types, constants and tables for the planar push rollout block.
// Used by ppe_ctrl, ppe_datapath and planar_push_euler_rollout; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

  localparam int DataW = 32;
  localparam int OpndW = 34;
  localparam int ProdW = 68;
  localparam int SumW  = 70;
  localparam int InW   = 9 * DataW;
  localparam int OutW  = 6 * DataW;
  localparam int CfgIdxW = 3;
  localparam int StepW = 10;
  localparam int SeqW  = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_SCALE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPIN_SCALE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY_STEP  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PUSHER_OFFSET = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT    = 3'd5;

  localparam logic [15:0]      TimeStepRst  = 16'd655;
  localparam logic [StepW-1:0] StepCountRst = 10'd11;

  // fixed constants of the sine/cosine evaluation
  localparam logic [OpndW-1:0] InvTwoPi   = 34'd683565276;
  localparam logic [OpndW-1:0] HalfPiQ30  = 34'd1686629713;
  localparam logic [30:0]      Q30One     = 31'h4000_0000;

  // micro-op sequence positions
  localparam logic [SeqW-1:0] SeqLast = 6'd38;

  typedef enum logic [4:0] {
    OP_PHASE, OP_XQ, OP_X2, OP_HM, OP_HD, OP_SQ, OP_SC,
    OP_FTC, OP_FNS, OP_FNC, OP_FTS, OP_POFT, OP_CPFN,
    OP_VXT, OP_FXA, OP_VYT, OP_FYA, OP_WT, OP_TQS
  } op_e;

  typedef struct packed {
    logic       load;
    logic       issue;
    op_e        op;
    logic [3:0] kidx;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic [StepW-1:0] step_count;
  } dp_stat_t;

  // Horner divisors: sine terms first, then cosine terms
  function automatic logic [7:0] div_k(input logic [3:0] kidx);
    logic [7:0] k;
    case (kidx)
      4'd0:    k = 8'd110;
      4'd1:    k = 8'd72;
      4'd2:    k = 8'd42;
      4'd3:    k = 8'd20;
      4'd4:    k = 8'd6;
      4'd5:    k = 8'd132;
      4'd6:    k = 8'd90;
      4'd7:    k = 8'd56;
      4'd8:    k = 8'd30;
      4'd9:    k = 8'd12;
      4'd10:   k = 8'd2;
      default: k = 8'd2;
    endcase
    return k;
  endfunction

  // reciprocals floor(2^34 / k), capped below 2^33
  function automatic logic [32:0] div_recip(input logic [3:0] kidx);
    logic [32:0] m;
    case (kidx)
      4'd0:    m = 33'd156180628;
      4'd1:    m = 33'd238609294;
      4'd2:    m = 33'd409044504;
      4'd3:    m = 33'd858993459;
      4'd4:    m = 33'd2863311530;
      4'd5:    m = 33'd130150524;
      4'd6:    m = 33'd190887435;
      4'd7:    m = 33'd306783378;
      4'd8:    m = 33'd572662306;
      4'd9:    m = 33'd1431655765;
      4'd10:   m = 33'd8589934591;
      default: m = 33'd8589934591;
    endcase
    return m;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > $signed({{(SumW-DataW+1){1'b0}}, {(DataW-1){1'b1}}})) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (v < $signed({{(SumW-DataW+1){1'b1}}, {(DataW-1){1'b0}}})) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ppe_ctrl.sv */
// Controller for the planar push rollout: beat handshakes, step and micro-op
// sequencing. Depends on ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_ctrl import ppe_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_e;

  state_e           state_q;
  logic             ph_q;
  logic [SeqW-1:0]  idx_q;
  logic [StepW-1:0] step_q;
  logic             oval_q;

  op_e        seq_op;
  logic [3:0] seq_k;
  logic [SeqW-1:0] kofs;

  // micro-op program of one Euler step
  always_comb begin
    seq_op = OP_SC;
    seq_k  = 4'd0;
    kofs   = '0;
    if (idx_q >= 6'd3 && idx_q <= 6'd12) begin
      seq_op = idx_q[0] ? OP_HM : OP_HD;
      kofs   = (idx_q - 6'd3) >> 1;
      seq_k  = kofs[3:0];
    end else if (idx_q >= 6'd14 && idx_q <= 6'd25) begin
      seq_op = idx_q[0] ? OP_HD : OP_HM;
      kofs   = ((idx_q - 6'd14) >> 1) + 6'd5;
      seq_k  = kofs[3:0];
    end else begin
      case (idx_q)
        6'd0:    seq_op = OP_PHASE;
        6'd1:    seq_op = OP_XQ;
        6'd2:    seq_op = OP_X2;
        6'd13:   seq_op = OP_SQ;
        6'd26:   seq_op = OP_SC;
        6'd27:   seq_op = OP_FTC;
        6'd28:   seq_op = OP_FNS;
        6'd29:   seq_op = OP_FNC;
        6'd30:   seq_op = OP_FTS;
        6'd31:   seq_op = OP_POFT;
        6'd32:   seq_op = OP_CPFN;
        6'd33:   seq_op = OP_VXT;
        6'd34:   seq_op = OP_FXA;
        6'd35:   seq_op = OP_VYT;
        6'd36:   seq_op = OP_FYA;
        6'd37:   seq_op = OP_WT;
        6'd38:   seq_op = OP_TQS;
        default: seq_op = OP_SC;
      endcase
    end
  end

  // commands
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = oval_q;
  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.issue  = (state_q == S_RUN) && !ph_q;
  assign cmd_o.op     = seq_op;
  assign cmd_o.kidx   = seq_k;
  assign cmd_o.finish = (state_q == S_FIN) && (!oval_q || out_ready_i);

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 1'b0;
      idx_q   <= '0;
      step_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      oval_q <= cmd_o.finish ? 1'b1 : (oval_q && !out_ready_i);
      case (state_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            state_q <= (stat_i.step_count == '0) ? S_FIN : S_RUN;
            ph_q    <= 1'b0;
            idx_q   <= '0;
            step_q  <= '0;
          end
        end
        S_RUN: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (idx_q == SeqLast) begin
              idx_q <= '0;
              if ({1'b0, step_q} + 11'd1 == {1'b0, stat_i.step_count}) begin
                state_q <= S_FIN;
              end else begin
                step_q <= step_q + 10'd1;
              end
            end else begin
              idx_q <= idx_q + 6'd1;
            end
          end
        end
        S_FIN: begin
          if (cmd_o.finish) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ppe_datapath.sv */
// Datapath for the planar push rollout: configuration registers, body state,
// shared 34x34 multiplier and write-back logic. Depends on ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_datapath import ppe_pkg::*; #(
  parameter int FracBits = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ctl_cmd_t             cmd_i,
  output dp_stat_t                  stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [DataW-1:0]     cfg_data_i,
  input  wire logic [InW-1:0]       in_data_i,
  output logic      [OutW-1:0]      out_data_o
);

  localparam int Sh = 30 - FracBits;

  // configuration
  logic [15:0]             ts_q;
  logic [DataW-1:0]        as_q, ss_q, g_q;
  logic signed [DataW-1:0] po_q;
  logic [StepW-1:0]        sc_q;

  // state, control and intermediates
  logic signed [DataW-1:0] x_q, vx_q, y_q, vy_q, a_q, w_q;
  logic signed [DataW-1:0] cp_q, fn_q, ft_q;
  logic signed [DataW-1:0] s_q, c_q, fx_q, fy_q, tq_q;
  logic signed [SumW-1:0]  t1_q;
  logic signed [DataW-1:0] nx_q, nvx_q, ny_q, nvy_q, na_q;
  logic [1:0]  quad_q;
  logic [29:0] r_q;
  logic [30:0] xq_q, p_q, sq_q, cq_q;
  logic [31:0] x2_q, m_q;
  logic [OutW-1:0] out_q;

  // multiplier stage
  logic signed [OpndW-1:0] opa, opb;
  logic signed [ProdW-1:0] prod_q;
  op_e        wop_q;
  logic [3:0] wk_q;
  logic       wv_q;

  function automatic logic signed [OpndW-1:0] sx(input logic signed [DataW-1:0] v);
    return {{(OpndW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic signed [SumW-1:0] sx70(input logic signed [DataW-1:0] v);
    return {{(SumW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic [DataW-1:0] rnd(input logic [30:0] mag);
    logic [DataW-1:0] t;
    t = {1'b0, mag} + (32'd1 << (Sh - 1));
    return t >> Sh;
  endfunction

  assign stat_o.step_count = sc_q;
  assign out_data_o = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TimeStepRst;
      as_q <= '0;
      ss_q <= '0;
      g_q  <= '0;
      po_q <= '0;
      sc_q <= StepCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP:     ts_q <= cfg_data_i[15:0];
        CFG_ACCEL_SCALE:   as_q <= cfg_data_i;
        CFG_SPIN_SCALE:    ss_q <= cfg_data_i;
        CFG_GRAVITY_STEP:  g_q  <= cfg_data_i;
        CFG_PUSHER_OFFSET: po_q <= cfg_data_i;
        CFG_STEP_COUNT:    sc_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // operand select
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.op)
      OP_PHASE: begin opa = sx(a_q);              opb = InvTwoPi; end
      OP_XQ:    begin opa = {4'b0, r_q};          opb = HalfPiQ30; end
      OP_X2:    begin opa = {3'b0, xq_q};         opb = {3'b0, xq_q}; end
      OP_HM:    begin opa = {2'b0, x2_q};         opb = {3'b0, p_q}; end
      OP_HD:    begin opa = {2'b0, m_q};          opb = {1'b0, div_recip(cmd_i.kidx)}; end
      OP_SQ:    begin opa = {3'b0, xq_q};         opb = {3'b0, p_q}; end
      OP_FTC:   begin opa = sx(ft_q);             opb = sx(c_q); end
      OP_FNS:   begin opa = sx(fn_q);             opb = sx(s_q); end
      OP_FNC:   begin opa = sx(fn_q);             opb = sx(c_q); end
      OP_FTS:   begin opa = sx(ft_q);             opb = sx(s_q); end
      OP_POFT:  begin opa = sx(po_q);             opb = sx(ft_q); end
      OP_CPFN:  begin opa = sx(cp_q);             opb = sx(fn_q); end
      OP_VXT:   begin opa = sx(vx_q);             opb = {18'b0, ts_q}; end
      OP_FXA:   begin opa = sx(fx_q);             opb = {2'b0, as_q}; end
      OP_VYT:   begin opa = sx(vy_q);             opb = {18'b0, ts_q}; end
      OP_FYA:   begin opa = sx(fy_q);             opb = {2'b0, as_q}; end
      OP_WT:    begin opa = sx(w_q);              opb = {18'b0, ts_q}; end
      OP_TQS:   begin opa = sx(tq_q);             opb = {2'b0, ss_q}; end
      default:  begin opa = '0;                   opb = '0; end
    endcase
  end

  // shared multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
    end else begin
      wv_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q <= opa * opb;
      wop_q  <= cmd_i.op;
      wk_q   <= cmd_i.kidx;
    end
  end

  // write-back arithmetic
  logic signed [ProdW-1:0] fl;
  logic signed [SumW-1:0]  fl70;
  logic [31:0] q0, rem, qd;
  logic [39:0] qk;
  logic [7:0]  kk;
  logic [32:0] sqr;
  logic [31:0] phase;

  always_comb begin
    fl    = prod_q >>> FracBits;
    fl70  = {{(SumW-ProdW){fl[ProdW-1]}}, fl};
    kk    = div_k(wk_q);
    q0    = prod_q[65:34];
    qk    = q0 * kk;
    rem   = m_q - qk[31:0];
    qd    = q0 + {31'b0, (rem >= {24'b0, kk})};
    sqr   = prod_q[62:30];
    phase = prod_q[FracBits+31:FracBits];
  end

  // register updates
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= in_data_i[0*DataW +: DataW];
      vx_q <= in_data_i[1*DataW +: DataW];
      y_q  <= in_data_i[2*DataW +: DataW];
      vy_q <= in_data_i[3*DataW +: DataW];
      a_q  <= in_data_i[4*DataW +: DataW];
      w_q  <= in_data_i[5*DataW +: DataW];
      cp_q <= in_data_i[6*DataW +: DataW];
      fn_q <= in_data_i[7*DataW +: DataW];
      ft_q <= in_data_i[8*DataW +: DataW];
    end
    if (cmd_i.finish) begin
      out_q <= {w_q, a_q, vy_q, y_q, vx_q, x_q};
    end
    if (wv_q) begin
      case (wop_q)
        OP_PHASE: begin
          quad_q <= phase[31:30];
          r_q    <= phase[29:0];
          p_q    <= Q30One;
        end
        OP_XQ: xq_q <= prod_q[60:30];
        OP_X2: x2_q <= prod_q[61:30];
        OP_HM: m_q  <= prod_q[61:30];
        OP_HD: begin
          p_q  <= Q30One - qd[30:0];
          cq_q <= (qd >= {1'b0, Q30One}) ? 31'd0 : (Q30One - qd[30:0]);
        end
        OP_SQ: begin
          sq_q <= (sqr > {2'b0, Q30One}) ? Q30One : sqr[30:0];
          p_q  <= Q30One;
        end
        OP_SC: begin
          case (quad_q)
            2'd0:    begin s_q <= rnd(sq_q);  c_q <= rnd(cq_q);  end
            2'd1:    begin s_q <= rnd(cq_q);  c_q <= -rnd(sq_q); end
            2'd2:    begin s_q <= -rnd(sq_q); c_q <= -rnd(cq_q); end
            default: begin s_q <= -rnd(cq_q); c_q <= rnd(sq_q);  end
          endcase
        end
        // first products of each pair are kept at full width until summed
        OP_FTC:  t1_q <= fl70;
        OP_FNS:  fx_q <= sat32(t1_q - fl70);
        OP_FNC:  t1_q <= fl70;
        OP_FTS:  fy_q <= sat32(t1_q + fl70);
        OP_POFT: t1_q <= fl70;
        OP_CPFN: tq_q <= sat32(t1_q + fl70);
        OP_VXT:  nx_q  <= sat32(sx70(x_q) + fl70);
        OP_FXA:  nvx_q <= sat32(sx70(vx_q) + fl70);
        OP_VYT:  ny_q  <= sat32(sx70(y_q) + fl70);
        OP_FYA:  nvy_q <= sat32(sx70(vy_q) + fl70 - {{(SumW-DataW){1'b0}}, g_q});
        OP_WT:   na_q  <= sat32(sx70(a_q) + fl70);
        OP_TQS: begin
          // commit the whole step at once
          x_q  <= nx_q;
          vx_q <= nvx_q;
          y_q  <= ny_q;
          vy_q <= nvy_q;
          a_q  <= na_q;
          w_q  <= sat32(sx70(w_q) + fl70);
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/planar_push_euler_rollout.sv */
// Top level of the planar push rollout: stream ports and configuration port.
// Instantiates ppe_ctrl and ppe_datapath; depends on ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Runs step_count forward Euler steps of a planar rigid body under one
// contact control and returns the final state as one output beat. Each step
// is 39 micro-ops on one shared 34x34 multiplier, each issued and then
// written back; with a step count of zero the loaded state is returned
// unchanged. A new input beat is taken once the previous item has moved
// to the output register, even if that result has not yet been taken.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
// by the user only while the block is idle; the block does not enforce it.
module planar_push_euler_rollout import ppe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // in_x, in_vx, in_y, in_vy, in_angle, in_rate, contact_point,
  // normal_force, tangent_force; 32 bits each from bit 0 up
  input  wire logic [InW-1:0]     s_axis_tdata_i,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // out_x, out_vx, out_y, out_vy, out_angle, out_rate; 32 bits each from bit 0 up
  output logic      [OutW-1:0]    m_axis_tdata_o,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_data_i
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ppe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ppe_datapath #(
    .FracBits (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
